>>> rtl/core/fcf_pkg.sv
// Shared types and constants for the FIR convolution filter.
// No dependencies; used by fcf_ctrl, fcf_datapath and fir_convolution_filter.

package fcf_pkg;

    localparam int VALUE_W = 16;
    localparam int INDEX_W = 9;
    localparam int TAPS_W  = 10;
    localparam int OUT_W   = 41;
    localparam int PROD_W  = 2 * VALUE_W;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic coef_wr;
        logic hist_wr;
        logic hist_zero;
        logic acc_clear;
        logic issue;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic pipe_empty;
    } sts_t;

endpackage

>>> rtl/core/fcf_ctrl.sv
// Controller for the FIR convolution filter: handshakes, tap count register,
// tap sequencing. Depends on fcf_pkg.

module fcf_ctrl #(
    parameter int MAX_TAPS = 512
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  op,
    output logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fcf_pkg::TAPS_W-1:0]  cfg_data,
    input  fcf_pkg::sts_t               sts,
    output fcf_pkg::cmd_t               cmd,
    output logic [$clog2(MAX_TAPS)-1:0] tap_idx
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam int TW = CW + 1;

    fcf_pkg::state_t state_reg, state_next;
    logic [fcf_pkg::TAPS_W-1:0] tap_count_reg;
    logic [AW-1:0]              tap_reg, tap_next;
    logic                       out_valid_reg, out_valid_next;
    logic [CW-1:0]              taps;
    logic                       last_tap;
    logic                       accept;

    // tap count of zero acts as one, above the store depth as the depth
    always_comb
    begin
        if (tap_count_reg == '0)
            taps = CW'(1);
        else if (int'(tap_count_reg) > MAX_TAPS)
            taps = CW'(MAX_TAPS);
        else
            taps = CW'(tap_count_reg);
    end

    assign last_tap  = (TW'(tap_reg) + TW'(1)) == TW'(taps);
    assign in_ready  = (state_reg == fcf_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign tap_idx   = tap_reg;

    always_comb
    begin
        state_next     = state_reg;
        tap_next       = tap_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            fcf_pkg::ST_IDLE:
            begin
                tap_next = '0;
                if (accept)
                begin
                    if (op == fcf_pkg::OP_LOAD)
                        cmd.coef_wr = 1'b1;
                    if (op == fcf_pkg::OP_SAMPLE || op == fcf_pkg::OP_FLUSH)
                    begin
                        cmd.hist_wr   = 1'b1;
                        cmd.hist_zero = (op == fcf_pkg::OP_FLUSH);
                        cmd.acc_clear = 1'b1;
                        state_next    = fcf_pkg::ST_ISSUE;
                    end
                end
            end
            fcf_pkg::ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (last_tap)
                    state_next = fcf_pkg::ST_DRAIN;
                else
                    tap_next = tap_reg + AW'(1);
            end
            fcf_pkg::ST_DRAIN:
            begin
                // result slot must be free or emptying this cycle
                if (sts.pipe_empty && (!out_valid_reg || out_ready))
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = fcf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fcf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcf_pkg::ST_IDLE;
            tap_reg       <= '0;
            out_valid_reg <= 1'b0;
            tap_count_reg <= fcf_pkg::TAPS_W'(512);
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                tap_count_reg <= cfg_data;
        end
    end

endmodule

>>> rtl/core/fcf_datapath.sv
// Datapath for the FIR convolution filter: coefficient and sample stores,
// shared multiply-accumulate, output register. Depends on fcf_pkg.

module fcf_datapath #(
    parameter int MAX_TAPS = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fcf_pkg::cmd_t                     cmd,
    input  logic [$clog2(MAX_TAPS)-1:0]       tap_idx,
    input  logic [fcf_pkg::INDEX_W-1:0]       coef_index,
    input  logic signed [fcf_pkg::VALUE_W-1:0] value,
    output fcf_pkg::sts_t                     sts,
    output logic signed [fcf_pkg::OUT_W-1:0]  filtered
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = (33 + AW > 42) ? 33 + AW : 42;
    localparam int VW    = fcf_pkg::VALUE_W;
    localparam int OW    = fcf_pkg::OUT_W;

    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-OW+1){1'b1}}, {(OW-1){1'b0}}};

    logic signed [VW-1:0] coef_mem [MAX_TAPS];
    logic signed [VW-1:0] hist_mem [MAX_TAPS];

    logic [AW-1:0]  head_reg, head_next;
    logic [AW-1:0]  pos_reg, pos_next;
    logic [CW-1:0]  fill_reg, fill_next;
    logic           v1_reg, live1_reg, v2_reg;
    logic signed [VW-1:0]             coef_rd_reg, hist_rd_reg;
    logic signed [fcf_pkg::PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]          acc_reg, acc_next;
    logic signed [OW-1:0]             filtered_reg, filtered_next;
    logic                             coef_in_range;
    logic                             live;

    assign coef_in_range = int'(coef_index) < MAX_TAPS;
    // a tap is live once more samples than its index have entered since reset
    assign live          = (CW + 1)'(tap_idx) < (CW + 1)'(fill_reg);
    assign sts.pipe_empty = !v1_reg && !v2_reg;
    assign filtered      = filtered_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.coef_wr && coef_in_range)
            coef_mem[AW'(coef_index)] <= value;
        coef_rd_reg <= coef_mem[tap_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hist_wr)
            hist_mem[head_reg] <= cmd.hist_zero ? '0 : value;
        hist_rd_reg <= hist_mem[pos_reg];
    end

    always_comb
    begin
        head_next = head_reg;
        pos_next  = pos_reg;
        fill_next = fill_reg;
        if (cmd.hist_wr)
        begin
            pos_next  = head_reg;
            head_next = (int'(head_reg) == MAX_TAPS - 1) ? '0 : head_reg + AW'(1);
            if (int'(fill_reg) != MAX_TAPS)
                fill_next = fill_reg + CW'(1);
        end
        else if (cmd.issue)
        begin
            pos_next = (pos_reg == '0) ? AW'(MAX_TAPS - 1) : pos_reg - AW'(1);
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_clear)
            acc_next = '0;
        else if (v2_reg)
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    always_comb
    begin
        if (acc_reg > SAT_HI)
            filtered_next = OW'(SAT_HI);
        else if (acc_reg < SAT_LO)
            filtered_next = OW'(SAT_LO);
        else
            filtered_next = acc_reg[OW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            pos_reg   <= '0;
            fill_reg  <= '0;
            v1_reg    <= 1'b0;
            live1_reg <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            pos_reg   <= pos_next;
            fill_reg  <= fill_next;
            v1_reg    <= cmd.issue;
            live1_reg <= cmd.issue && live;
            v2_reg    <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // kept as a signed product; an unsized zero beside it would make it unsigned
        if (live1_reg)
            prod_reg <= coef_rd_reg * hist_rd_reg;
        else
            prod_reg <= '0;
        acc_reg  <= acc_next;
        if (cmd.out_load)
            filtered_reg <= filtered_next;
    end

endmodule

>>> rtl/core/fir_convolution_filter.sv
// Top level of the direct-form FIR convolution filter.
// Depends on fcf_pkg, fcf_ctrl and fcf_datapath.

// A load request (op 0) writes one Q1.15 coefficient and gives no result;
// op 3 is taken and ignored. A sample (op 1) or flush (op 2, zero sample)
// request enters the delay line and yields one exact Q11.30 sum over the
// taps in use: the request is taken, each tap passes in turn through the
// single shared multiply-accumulate (one read port on each store), then the
// pipeline drains and the output register is loaded. The next request is
// taken once the result is in the output register, even while that result
// still waits to be taken. The delay line needs no clearing after reset.
// Set tap_count only while the filter is idle.

module fir_convolution_filter #(
    parameter int MAX_TAPS = 512
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         op,
    input  logic [fcf_pkg::INDEX_W-1:0]        coef_index,
    input  logic signed [fcf_pkg::VALUE_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [fcf_pkg::OUT_W-1:0]   filtered,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fcf_pkg::TAPS_W-1:0]         cfg_data
);

    fcf_pkg::cmd_t                cmd;
    fcf_pkg::sts_t                sts;
    logic [$clog2(MAX_TAPS)-1:0]  tap_idx;

    fcf_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .sts       (sts),
        .cmd       (cmd),
        .tap_idx   (tap_idx)
    );

    fcf_datapath #(
        .MAX_TAPS (MAX_TAPS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .tap_idx    (tap_idx),
        .coef_index (coef_index),
        .value      (value),
        .sts        (sts),
        .filtered   (filtered)
    );

endmodule
